// ----- hw/rtl/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared widths, constants, result codes and the result struct.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Width of the message length register (range 16 to 64)
  localparam int unsigned LengthBits = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgW       = 32;

  // Header field values
  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Reset value of the maximum length register
  localparam logic [CfgW-1:0] MAX_LENGTH_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNMASKED = 2'd1,
    ERR_TYPE     = 2'd2,
    ERR_TOO_BIG  = 2'd3
  } error_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic             last;
    error_e           err_code;
  } result_t;

endpackage

// ----- hw/rtl/wsfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver input stage
// Registers one received byte; refills in the cycle the byte moves on.
// ----------------------------------------------------------------------------
module wsfr_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wsfr_pkg::ByteW-1:0] byte_i,
  input  logic                       advance_i,
  output logic                       valid_o,
  output logic [wsfr_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [wsfr_pkg::ByteW-1:0] byte_q;

  // Free, or emptying this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- hw/rtl/wsfr_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver parser
// Frame state machine: header, extended length, mask key, payload unmasking.
// ----------------------------------------------------------------------------
module wsfr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [wsfr_pkg::ByteW-1:0] byte_i,
  input  logic [wsfr_pkg::CfgW-1:0]  max_length_i,
  output logic                       res_valid_o,
  output wsfr_pkg::result_t          res_o
);

  localparam int unsigned LenW = wsfr_pkg::LengthBits;
  localparam int unsigned CmpW = (LenW > wsfr_pkg::CfgW) ? LenW : wsfr_pkg::CfgW;

  // Phase codes
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DEAD    = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [3:0]      frame_type_q, frame_type_d;
  logic [3:0]      ext_left_q, ext_left_d;
  logic [LenW-1:0] msg_len_q, msg_len_d;
  logic [LenW-1:0] remaining_q, remaining_d;
  logic [1:0]      byte_idx_q, byte_idx_d;
  logic [31:0]     mask_key_q, mask_key_d;
  logic [1:0]      mask_count_q, mask_count_d;
  logic            len_ovf_q, len_ovf_d;

  logic [LenW-1:0] chk_len;
  logic            chk_ovf;
  logic            too_big;
  logic [LenW-1:0] shifted_len;
  logic [6:0]      len7;
  logic [7:0]      key_byte;

  // Length limit check on the length being completed
  assign too_big = chk_ovf || (CmpW'(chk_len) > CmpW'(max_length_i));

  assign shifted_len = {msg_len_q[LenW-9:0], byte_i};
  assign len7        = byte_i[6:0];

  // Mask byte for this payload position, first key byte in the top bits
  always_comb begin
    unique case (byte_idx_q)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    frame_type_d = frame_type_q;
    ext_left_d   = ext_left_q;
    msg_len_d    = msg_len_q;
    remaining_d  = remaining_q;
    byte_idx_d   = byte_idx_q;
    mask_key_d   = mask_key_q;
    mask_count_d = mask_count_q;
    len_ovf_d    = len_ovf_q;
    chk_len      = msg_len_q;
    chk_ovf      = len_ovf_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: wsfr_pkg::KIND_DATA, data_byte: '0, last: 1'b0,
                     err_code: wsfr_pkg::ERR_NONE};

    if (step_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          frame_type_d = byte_i[3:0];
          phase_d      = PH_HDR1;
        end
        PH_HDR1: begin
          chk_len = LenW'(len7);
          chk_ovf = 1'b0;
          if (!byte_i[7]) begin
            phase_d        = PH_DEAD;
            res_valid_o    = 1'b1;
            res_o.kind     = wsfr_pkg::KIND_ERROR;
            res_o.err_code = wsfr_pkg::ERR_UNMASKED;
          end else if (frame_type_q != wsfr_pkg::OPCODE_TEXT) begin
            phase_d        = PH_DEAD;
            res_valid_o    = 1'b1;
            res_o.kind     = wsfr_pkg::KIND_ERROR;
            res_o.err_code = wsfr_pkg::ERR_TYPE;
          end else if (len7 == wsfr_pkg::LEN7_EXT16 || len7 == wsfr_pkg::LEN7_EXT64) begin
            len_ovf_d  = 1'b0;
            msg_len_d  = '0;
            ext_left_d = (len7 == wsfr_pkg::LEN7_EXT16) ? wsfr_pkg::EXT16_BYTES
                                                         : wsfr_pkg::EXT64_BYTES;
            phase_d    = PH_EXTLEN;
          end else begin
            len_ovf_d = 1'b0;
            msg_len_d = LenW'(len7);
            if (too_big) begin
              phase_d        = PH_DEAD;
              res_valid_o    = 1'b1;
              res_o.kind     = wsfr_pkg::KIND_ERROR;
              res_o.err_code = wsfr_pkg::ERR_TOO_BIG;
            end else begin
              mask_count_d = 2'd0;
              phase_d      = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          // Any bit pushed out of the length register marks the message too big
          len_ovf_d  = len_ovf_q || (msg_len_q[LenW-1 -: 8] != 8'd0);
          msg_len_d  = shifted_len;
          ext_left_d = ext_left_q - 4'd1;
          chk_len    = shifted_len;
          chk_ovf    = len_ovf_d;
          if (ext_left_d == 4'd0) begin
            if (too_big) begin
              phase_d        = PH_DEAD;
              res_valid_o    = 1'b1;
              res_o.kind     = wsfr_pkg::KIND_ERROR;
              res_o.err_code = wsfr_pkg::ERR_TOO_BIG;
            end else begin
              mask_count_d = 2'd0;
              phase_d      = PH_MASK;
            end
          end
        end
        PH_MASK: begin
          mask_key_d   = {mask_key_q[23:0], byte_i};
          mask_count_d = mask_count_q + 2'd1;
          if (mask_count_d == 2'd0) begin
            byte_idx_d  = 2'd0;
            remaining_d = msg_len_q;
            if (msg_len_q == '0) begin
              phase_d     = PH_HDR0;
              res_valid_o = 1'b1;
              res_o.kind  = wsfr_pkg::KIND_EMPTY;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          byte_idx_d      = byte_idx_q + 2'd1;
          remaining_d     = remaining_q - LenW'(1);
          res_valid_o     = 1'b1;
          res_o.kind      = wsfr_pkg::KIND_DATA;
          res_o.data_byte = byte_i ^ key_byte;
          // Last byte when at most one remains
          res_o.last      = (remaining_q[LenW-1:1] == '0);
          if (res_o.last) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          // Closed after an error: bytes are dropped
          phase_d = PH_DEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      frame_type_q <= '0;
      ext_left_q   <= '0;
      msg_len_q    <= '0;
      remaining_q  <= '0;
      byte_idx_q   <= '0;
      mask_key_q   <= '0;
      mask_count_q <= '0;
      len_ovf_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      frame_type_q <= frame_type_d;
      ext_left_q   <= ext_left_d;
      msg_len_q    <= msg_len_d;
      remaining_q  <= remaining_d;
      byte_idx_q   <= byte_idx_d;
      mask_key_q   <= mask_key_d;
      mask_count_q <= mask_count_d;
      len_ovf_q    <= len_ovf_d;
    end
  end

endmodule

// ----- hw/rtl/wsfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver output stage
// Result register; takes a new result in the cycle the old one is taken.
// ----------------------------------------------------------------------------
module wsfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  wsfr_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsfr_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  wsfr_pkg::result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/websocket_frame_receiver.sv -----
// A byte accepted is held in the input register; the parser decodes it combinationally,
// and its result is registered in the output register once that register can take it.
// Throughput: one byte per cycle; every byte, with or without a result, waits while
// a result is held in the stalled output register.
// Reset: asynchronous, active low; parser to first header byte, both stages empty,
// max_length to 65536. After an error, bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Client-to-server deframer: checks header, length and mask, unmasks payload.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [wsfr_pkg::CfgW-1:0]  max_length_i,
  // Byte input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wsfr_pkg::ByteW-1:0] byte_in_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [wsfr_pkg::ByteW-1:0] data_byte_o,
  output logic                       last_o,
  output logic [1:0]                 err_code_o
);

  logic [wsfr_pkg::CfgW-1:0]  max_length_q;
  logic                       s_valid;
  logic [wsfr_pkg::ByteW-1:0] s_byte;
  logic                       advance;
  logic                       can_load;
  logic                       res_valid;
  wsfr_pkg::result_t          res;
  wsfr_pkg::result_t          out_res;

  // Configuration register, every transaction taken at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= wsfr_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid_i) begin
      max_length_q <= max_length_i;
    end
  end

  // Byte moves on when the result register can take its result
  assign advance = s_valid && can_load;

  wsfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_i     (byte_in_i),
    .advance_i  (advance),
    .valid_o    (s_valid),
    .byte_o     (s_byte)
  );

  wsfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (s_byte),
    .max_length_i (max_length_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o      = out_res.kind;
  assign data_byte_o = out_res.data_byte;
  assign last_o      = out_res.last;
  assign err_code_o  = out_res.err_code;

endmodule

// ----- dv/wsfr_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver stream checker
// Watches the configuration, byte and result channels, tracks the deframer
// state for every accepted byte and compares each result transaction with
// the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module wsfr_stream_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [wsfr_pkg::CfgW-1:0]  max_length_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [wsfr_pkg::ByteW-1:0] byte_in_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [1:0]                 kind_i,
  input  logic [wsfr_pkg::ByteW-1:0] data_byte_i,
  input  logic                       last_i,
  input  logic [1:0]                 err_code_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                results_due_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned LenW        = wsfr_pkg::LengthBits;

  typedef enum logic [2:0] {
    ST_HDR_FIRST,
    ST_HDR_SECOND,
    ST_EXT_LEN,
    ST_MASK_KEY,
    ST_PAYLOAD,
    ST_CLOSED
  } parse_state_e;

  // Shadow copy of the parser
  parse_state_e                parse_state;
  logic [3:0]                  opcode_q;
  logic [3:0]                  ext_bytes_left;
  logic [LenW-1:0]             msg_length;
  logic [63:0]                 payload_seen;
  logic [31:0]                 mask_word;
  logic [1:0]                  mask_bytes;
  logic                        conn_closed;
  logic                        length_wrapped;
  logic [wsfr_pkg::CfgW-1:0]   max_length;

  // Results still owed by the block, oldest first
  wsfr_pkg::result_t           frame_results_q[$];

  // Advance the shadow parser by one byte; at most one result comes out
  task automatic deframe_byte(input logic [wsfr_pkg::ByteW-1:0] b, output bit produced,
                              output wsfr_pkg::result_t res);
    bit               len_ready;
    wsfr_pkg::error_e err;
    logic [7:0]       key;
    produced  = 1'b0;
    len_ready = 1'b0;
    err       = wsfr_pkg::ERR_NONE;
    res       = '0;
    if (conn_closed) return;
    case (parse_state)
      ST_HDR_FIRST: begin
        // FIN and RSV bits are ignored
        opcode_q    = b[3:0];
        parse_state = ST_HDR_SECOND;
      end
      ST_HDR_SECOND: begin
        // unmasked beats a wrong opcode
        if (!b[7]) begin
          err = wsfr_pkg::ERR_UNMASKED;
        end else if (opcode_q != wsfr_pkg::OPCODE_TEXT) begin
          err = wsfr_pkg::ERR_TYPE;
        end else begin
          msg_length     = LenW'(b[6:0]);
          payload_seen   = '0;
          length_wrapped = 1'b0;
          if (b[6:0] == wsfr_pkg::LEN7_EXT16 || b[6:0] == wsfr_pkg::LEN7_EXT64) begin
            ext_bytes_left = (b[6:0] == wsfr_pkg::LEN7_EXT16) ? wsfr_pkg::EXT16_BYTES
                                                               : wsfr_pkg::EXT64_BYTES;
            msg_length     = '0;
            parse_state    = ST_EXT_LEN;
          end else begin
            len_ready = 1'b1;
          end
        end
      end
      ST_EXT_LEN: begin
        // bits shifted out of the length register make the message too big
        if ((msg_length >> (LenW - 8)) != 0) length_wrapped = 1'b1;
        msg_length     = {msg_length[LenW-9:0], b};
        ext_bytes_left = ext_bytes_left - 4'd1;
        len_ready      = (ext_bytes_left == 4'd0);
      end
      ST_MASK_KEY: begin
        mask_word  = {mask_word[23:0], b};
        mask_bytes = mask_bytes + 2'd1;
        if (mask_bytes == 2'd0) begin
          payload_seen = '0;
          if (msg_length == 0) begin
            parse_state = ST_HDR_FIRST;
            produced    = 1'b1;
            res.kind    = wsfr_pkg::KIND_EMPTY;
          end else begin
            parse_state = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        key           = 8'(mask_word >> (5'd24 - {payload_seen[1:0], 3'b000}));
        payload_seen  = payload_seen + 64'd1;
        produced      = 1'b1;
        res.kind      = wsfr_pkg::KIND_DATA;
        res.data_byte = b ^ key;
        res.last      = (payload_seen >= 64'(msg_length));
        if (res.last) parse_state = ST_HDR_FIRST;
      end
      default: ;
    endcase
    // length complete: check against the limit, then collect the key
    if (len_ready) begin
      if (length_wrapped || 64'(msg_length) > 64'(max_length)) begin
        err = wsfr_pkg::ERR_TOO_BIG;
      end else begin
        mask_bytes  = '0;
        mask_word   = '0;
        parse_state = ST_MASK_KEY;
      end
    end
    // any error closes the connection for good
    if (err != wsfr_pkg::ERR_NONE) begin
      conn_closed  = 1'b1;
      parse_state  = ST_CLOSED;
      produced     = 1'b1;
      res.kind     = wsfr_pkg::KIND_ERROR;
      res.err_code = err;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    wsfr_pkg::result_t predicted;
    bit                produced;
    if (!rst_ni) begin
      parse_state      = ST_HDR_FIRST;
      opcode_q         = '0;
      ext_bytes_left   = '0;
      msg_length       = '0;
      payload_seen     = '0;
      mask_word        = '0;
      mask_bytes       = '0;
      conn_closed      = 1'b0;
      length_wrapped   = 1'b0;
      max_length       = wsfr_pkg::MAX_LENGTH_RESET;
      mismatch_count_o = 0;
      frame_results_q.delete();
    end else begin
      // result transaction: always from an older byte, so check it first
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= ReportLimit)
            $display("%0t: unexpected result kind=%0d data=%02h last=%0b err=%0d",
                     $realtime, kind_i, data_byte_i, last_i, err_code_i);
        end else begin
          predicted = frame_results_q.pop_front();
          if (kind_i !== predicted.kind || data_byte_i !== predicted.data_byte ||
              last_i !== predicted.last || err_code_i !== predicted.err_code) begin
            mismatch_count_o++;
            if (mismatch_count_o <= ReportLimit)
              $display({"%0t: result differs: exp kind=%0d data=%02h last=%0b err=%0d,",
                        " got kind=%0d data=%02h last=%0b err=%0d"},
                       $realtime, predicted.kind, predicted.data_byte, predicted.last,
                       predicted.err_code, kind_i, data_byte_i, last_i, err_code_i);
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) max_length = max_length_i;
      // byte transaction
      if (in_valid_i && in_ready_i) begin
        deframe_byte(byte_in_i, produced, predicted);
        if (produced) frame_results_q.insert(frame_results_q.size(), predicted);
      end
    end
    results_due_o = frame_results_q.size();
  end

endmodule

// ----- dv/tb_websocket_frame_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams well-formed masked text frames of mixed length encodings under
// several maximum length settings, with random gaps and stalls on both
// channels and long result back-pressure, then closes with one error frame
// followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver;

  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseBytes  = 180;
  localparam int unsigned MaxFrameLen = 200;

  typedef enum int unsigned {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_enc_e;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [wsfr_pkg::CfgW-1:0]  max_length = '0;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic [wsfr_pkg::ByteW-1:0] byte_in    = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [1:0]                 kind;
  logic [wsfr_pkg::ByteW-1:0] data_byte;
  logic                       last;
  logic [1:0]                 err_code;
  int unsigned                mismatches;
  int unsigned                results_due;

  bit                tx_burst   = 1'b0;
  bit                rx_burst   = 1'b0;
  int unsigned       bytes_sent = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  websocket_frame_receiver DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .max_length_i (max_length),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .byte_in_i    (byte_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .data_byte_o  (data_byte),
    .last_o       (last),
    .err_code_o   (err_code)
  );

  wsfr_stream_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .max_length_i     (max_length),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .byte_in_i        (byte_in),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .data_byte_i      (data_byte),
    .last_i           (last),
    .err_code_i       (err_code),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due)
  );

  // One byte transaction, after a random gap
  task automatic put_byte(input logic [wsfr_pkg::ByteW-1:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    byte_in  = b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stop sending and let the pipeline drain completely
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [wsfr_pkg::CfgW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid  = 1'b1;
    max_length = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Masked text frame with a random payload
  task automatic send_frame(input logic [3:0] flags, input logic [63:0] len,
                            input len_enc_e enc, input logic [31:0] key);
    put_byte({flags, wsfr_pkg::OPCODE_TEXT});
    case (enc)
      LEN_SHORT: put_byte({1'b1, len[6:0]});
      LEN_EXT16: begin
        put_byte({1'b1, wsfr_pkg::LEN7_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({1'b1, wsfr_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
    for (longint unsigned n = 0; n < len; n++) put_byte(8'($urandom));
  endtask

  // Mostly short frames, now and then a long one or one right at the limit
  task automatic send_random_frame(input logic [wsfr_pkg::CfgW-1:0] limit);
    logic [63:0] len;
    int unsigned cap;
    int unsigned pick;
    len_enc_e    enc;
    cap  = (limit < MaxFrameLen) ? 32'(limit) : MaxFrameLen;
    pick = $urandom_range(0, 29);
    if (pick == 0)      len = 64'(cap);
    else if (pick == 1) len = 64'($urandom_range(0, cap));
    else                len = 64'($urandom_range(0, (cap < 12) ? cap : 12));
    if (len > 125) begin
      enc = $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64;
    end else begin
      case ($urandom_range(0, 5))
        0:       enc = LEN_EXT16;
        1:       enc = LEN_EXT64;
        default: enc = LEN_SHORT;
      endcase
    end
    send_frame(4'($urandom), len, enc, $urandom);
  endtask

  // Result side: random stalls, bursts, and a few long hold-offs
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (taken % 450 == 150) stall = HoldCycles;
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: cycles without any transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [wsfr_pkg::CfgW-1:0] limit;
    logic [63:0]               big;
    logic [3:0]                op;
    int unsigned               target;
    limit = wsfr_pkg::MAX_LENGTH_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty message with an all-zero key
    send_frame(4'h8, 64'd0, LEN_SHORT, 32'h0000_0000);
    // FIN clear, RSV set, all-ones key
    send_frame(4'h7, 64'd3, LEN_SHORT, 32'hFFFF_FFFF);
    // non-minimal 16-bit length
    send_frame(4'h0, 64'd1, LEN_EXT16, 32'h5AA5_C33C);

    // random frames under several length limits, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       limit = '0;
          2:       limit = '1;
          default: limit = $urandom_range(1, 150);
        endcase
        write_max_length(limit);
      end
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_frame(limit);
    end

    // closing error: the connection stays dead afterwards
    wait_idle();
    op = 4'($urandom_range(2, 16));
    case ($urandom_range(0, 3))
      0: begin
        put_byte({4'($urandom), wsfr_pkg::OPCODE_TEXT});
        put_byte({1'b0, 7'($urandom)});
      end
      1: begin
        put_byte({4'($urandom), op});
        put_byte({1'b1, 7'($urandom)});
      end
      2: begin
        // unmasked and wrong opcode: unmasked is reported
        put_byte({4'($urandom), op});
        put_byte({1'b0, 7'($urandom)});
      end
      default: begin
        limit = $urandom_range(0, 1000);
        write_max_length(limit);
        big = $urandom_range(0, 1) ? 64'(limit) + 64'd1
                                   : {32'($urandom) | 32'd1, 32'($urandom)};
        put_byte({4'($urandom), wsfr_pkg::OPCODE_TEXT});
        put_byte({1'b1, wsfr_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(big[8*i +: 8]);
      end
    endcase
    // bytes after the error must vanish
    repeat (20) put_byte(8'($urandom));
    @(negedge clk);
    in_valid = 1'b0;

    do @(negedge clk); while (results_due != 0);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_in_stage.sv
hw/rtl/wsfr_parser.sv
hw/rtl/wsfr_out_stage.sv
hw/rtl/websocket_frame_receiver.sv
dv/wsfr_stream_checker.sv
dv/tb_websocket_frame_receiver.sv
